### sv/pfac_pkg.sv
// Package: types and constants shared by the postfix code generator.
`default_nettype none
package pfac_pkg;

   // Operator characters
   localparam logic [7:0] SYM_ADD = 8'h2B;
   localparam logic [7:0] SYM_SUB = 8'h2D;
   localparam logic [7:0] SYM_MUL = 8'h2A;
   localparam logic [7:0] SYM_DIV = 8'h2F;

   // Instruction codes
   localparam logic [2:0] INSTR_LD   = 3'd0;
   localparam logic [2:0] INSTR_AD   = 3'd1;
   localparam logic [2:0] INSTR_SB   = 3'd2;
   localparam logic [2:0] INSTR_ML   = 3'd3;
   localparam logic [2:0] INSTR_DV   = 3'd4;
   localparam logic [2:0] INSTR_ST   = 3'd5;
   localparam logic [2:0] INSTR_NONE = 3'd6;

   // Error codes
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_UNDER = 2'd1;
   localparam logic [1:0] ERR_OVER  = 2'd2;
   localparam logic [1:0] ERR_TEMP  = 2'd3;

   localparam logic [7:0] TEMP_MAX = 8'd255;
   localparam int         ENTRY_W  = 9;

   typedef struct packed {
      logic [7:0] symbol;
      logic       end_of_expr;
   } req_word_type;

   typedef struct packed {
      logic [2:0] instr;
      logic       is_temp;
      logic [7:0] operand;
      logic [1:0] error;
      logic       last;
   } rsp_word_type;

   typedef struct packed {
      logic       is_temp;
      logic [7:0] value;
   } stack_entry_type;

   // One accepted character that causes results
   typedef struct packed {
      logic       valid;
      logic       is_op;     // 1: three words, 0: overflow error word
      logic [2:0] opcode;
      logic       err_left;
      logic       err_right;
      logic [7:0] temp_num;
      logic [1:0] err_store;
      logic [7:0] symbol;
   } issue_type;

endpackage
`default_nettype wire

### sv/pfac_ram.sv
// Generic single-write, dual-read RAM with registered read data.
`default_nettype none
module pfac_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read-first: a read of the entry being written returns old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule
`default_nettype wire

### sv/pfac_stack_ctrl.sv
// Stack pointer, temporary counter and operand stack memory.
`default_nettype none
module pfac_stack_ctrl import pfac_pkg::*; #(
   parameter int STACK_DEPTH = 128
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire req_word_type    req_word,
   output issue_type            issue,
   output stack_entry_type      left_entry,
   output stack_entry_type      right_entry
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    temp_ff, temp_in;

   logic          is_op;
   logic [2:0]    opcode;
   logic          err_left, err_right, temp_sat;
   logic [CW-1:0] count_m1, count_m2, count_pop;
   logic          push_op_ok, push_sym_ok;
   logic [7:0]    temp_next;
   logic [1:0]    err_store;
   logic          wr_en, rd_en;
   logic [CW-1:0] wr_ptr;
   logic [ENTRY_W-1:0] wr_data, rd_a, rd_b;

   always_comb begin
      is_op  = 1'b1;
      opcode = INSTR_LD;
      unique case (req_word.symbol)
         SYM_ADD: opcode = INSTR_AD;
         SYM_SUB: opcode = INSTR_SB;
         SYM_MUL: opcode = INSTR_ML;
         SYM_DIV: opcode = INSTR_DV;
         default: is_op = 1'b0;
      endcase
   end

   // two pops, then the temporary goes where the left operand was
   assign err_right   = (count_ff == '0);
   assign err_left    = (count_ff <= CW'(1));
   assign count_m1    = count_ff - CW'(1);
   assign count_m2    = count_ff - CW'(2);
   assign count_pop   = err_left ? '0 : count_m2;
   assign push_op_ok  = (count_pop < CW'(STACK_DEPTH));
   assign push_sym_ok = (count_ff < CW'(STACK_DEPTH));
   assign temp_sat    = (temp_ff == TEMP_MAX);
   assign temp_next   = temp_sat ? TEMP_MAX : temp_ff + 8'd1;

   always_comb begin
      priority if (temp_sat) begin
         err_store = ERR_TEMP;
      end else if (!push_op_ok) begin
         err_store = ERR_OVER;
      end else begin
         err_store = ERR_NONE;
      end
   end

   always_comb begin
      count_in = count_ff;
      temp_in  = temp_ff;
      if (accept) begin
         if (is_op) begin
            temp_in  = temp_next;
            count_in = push_op_ok ? count_pop + CW'(1) : count_pop;
         end else if (push_sym_ok) begin
            count_in = count_ff + CW'(1);
         end
         if (req_word.end_of_expr) begin
            count_in = '0;
            temp_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         temp_ff  <= '0;
      end else begin
         count_ff <= count_in;
         temp_ff  <= temp_in;
      end
   end

   assign rd_en   = accept && is_op;
   assign wr_en   = accept && (is_op ? push_op_ok : push_sym_ok);
   assign wr_ptr  = is_op ? count_pop : count_ff;
   assign wr_data = is_op ? {1'b1, temp_next} : {1'b0, req_word.symbol};

   pfac_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_ptr[AW-1:0]),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (count_m1[AW-1:0]),
      .rd_addr_b (count_m2[AW-1:0]),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   assign right_entry = stack_entry_type'(rd_a);
   assign left_entry  = stack_entry_type'(rd_b);

   always_comb begin
      issue.valid     = accept && (is_op || !push_sym_ok);
      issue.is_op     = is_op;
      issue.opcode    = opcode;
      issue.err_left  = err_left;
      issue.err_right = err_right;
      issue.temp_num  = temp_next;
      issue.err_store = err_store;
      issue.symbol    = req_word.symbol;
   end

endmodule
`default_nettype wire

### sv/pfac_emit.sv
// Result sequencer: holds one issued item and emits its words.
`default_nettype none
module pfac_emit import pfac_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire issue_type       issue,
   input  wire stack_entry_type left_entry,
   input  wire stack_entry_type right_entry,
   output logic                 busy,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_word_type         rsp_word
);

   // word within an operator: LD left, op right, ST temporary
   typedef enum logic [1:0] {
      STEP_LD,
      STEP_OP,
      STEP_ST
   } step_type;

   logic         s1_valid_ff, s1_valid_in;
   issue_type    s1_ff, s1_in;
   step_type     step_ff, step_in;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_ff, out_in;

   logic         out_load, emit, last_now;
   rsp_word_type word;

   assign out_load = !out_valid_ff || !rsp_stall;
   assign emit     = s1_valid_ff && out_load;
   assign last_now = !s1_ff.is_op || (step_ff == STEP_ST);
   assign busy     = s1_valid_ff && !(emit && last_now);

   always_comb begin
      word = '0;
      if (!s1_ff.is_op) begin
         word.instr   = INSTR_NONE;
         word.is_temp = 1'b0;
         word.operand = s1_ff.symbol;
         word.error   = ERR_OVER;
         word.last    = 1'b1;
      end else begin
         unique case (step_ff)
            STEP_LD: begin
               word.instr   = INSTR_LD;
               word.is_temp = s1_ff.err_left ? 1'b0 : left_entry.is_temp;
               word.operand = s1_ff.err_left ? 8'd0 : left_entry.value;
               word.error   = s1_ff.err_left ? ERR_UNDER : ERR_NONE;
            end
            STEP_OP: begin
               word.instr   = s1_ff.opcode;
               word.is_temp = s1_ff.err_right ? 1'b0 : right_entry.is_temp;
               word.operand = s1_ff.err_right ? 8'd0 : right_entry.value;
               word.error   = s1_ff.err_right ? ERR_UNDER : ERR_NONE;
            end
            default: begin
               word.instr   = INSTR_ST;
               word.is_temp = 1'b1;
               word.operand = s1_ff.temp_num;
               word.error   = s1_ff.err_store;
               word.last    = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_in        = s1_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_load) begin
         out_valid_in = emit;
         out_in       = word;
      end
      if (issue.valid) begin
         s1_valid_in = 1'b1;
         s1_in       = issue;
         step_in     = STEP_LD;
      end else if (emit && last_now) begin
         s1_valid_in = 1'b0;
      end else if (emit) begin
         step_in = (step_ff == STEP_LD) ? STEP_OP : STEP_ST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_ff   <= s1_in;
      step_ff <= step_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

endmodule
`default_nettype wire

### sv/postfix_to_accumulator_code.sv
// Top level: postfix expression to one-address (accumulator) code generator.
//  - req channel takes one character word per accept (req_valid high, req_stall low):
//    symbol and end_of_expr. rsp channel gives instruction words: instr, is_temp,
//    operand, error and last (set on the final word caused by a character).
//  - Operand characters are pushed onto the stack and give no word, except
//    on a full stack: then one error word (instr none, stack overflow).
//  - Operators + - * / give three words: LD left, op right, ST temporary.
//  - The first word of a character goes through the sequencer and output registers.
//  - An operand that is pushed gives no word and does not hold req_stall; words
//    leave one per cycle through the output register while rsp_stall is low.
//  - Stack pointer and temporary counter update at accept; both stack reads
//    and the temporary write hit the stack RAM in that same cycle, so a
//    following character sees the new stack with no interlock.
//  - The next character is taken in the cycle the last word of the current
//    one moves to the output register, even while that word waits there.
//  - rsp_stall holds the output word; the sequencer then stops and req_stall
//    rises once a character with pending words is held.
//  - Reset (synchronous) empties the stack and clears the temporary counter;
//    the stack RAM itself is not cleared. end_of_expr does the same after
//    its character's words are issued.
`default_nettype none
module postfix_to_accumulator_code import pfac_pkg::*; #(
   parameter int STACK_DEPTH = 128
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   logic            accept;
   logic            busy;
   issue_type       issue;
   stack_entry_type left_entry, right_entry;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   // stack pointer, temp counter, stack RAM
   pfac_stack_ctrl #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_word    (req_word),
      .issue       (issue),
      .left_entry  (left_entry),
      .right_entry (right_entry)
   );

   // word sequencer and output register
   pfac_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .issue       (issue),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

endmodule
`default_nettype wire

### bench/accumulator_code_checker.sv
`timescale 1ns / 100ps
// Checker: predicts the instruction words for each accepted character and compares them.
module accumulator_code_checker import pfac_pkg::*; #(
   parameter int STACK_DEPTH = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_word,
   output int           mismatch_count,
   output int           words_outstanding
);

   stack_entry_type operand_stack [STACK_DEPTH];
   int              stack_depth;
   logic [7:0]      temp_num;
   int              failures;
   rsp_word_type    expected_words [$];

   function automatic bit push_entry(stack_entry_type e);
      if (stack_depth >= STACK_DEPTH) return 1'b0;
      operand_stack[stack_depth] = e;
      stack_depth++;
      return 1'b1;
   endfunction

   // empty stack: operand 0, underflow flagged on the word that uses it
   function automatic void pop_entry(output stack_entry_type e, output logic [1:0] err);
      if (stack_depth == 0) begin
         e   = '0;
         err = ERR_UNDER;
      end else begin
         stack_depth--;
         e   = operand_stack[stack_depth];
         err = ERR_NONE;
      end
   endfunction

   function automatic void add_word(logic [2:0] instr, stack_entry_type e, logic [1:0] err,
                                    logic last);
      rsp_word_type w;
      w.instr   = instr;
      w.is_temp = e.is_temp;
      w.operand = e.value;
      w.error   = err;
      w.last    = last;
      expected_words.push_back(w);
   endfunction

   function automatic string word_text(rsp_word_type w);
      return $sformatf("instr %0d is_temp %0d operand %0d error %0d last %0d",
                       w.instr, w.is_temp, w.operand, w.error, w.last);
   endfunction

   function automatic void translate_symbol(req_word_type w);
      logic            is_op;
      logic [2:0]      opcode;
      stack_entry_type right, left, temp_entry, sym_entry;
      logic [1:0]      err_right, err_left, err_store;
      is_op  = 1'b1;
      opcode = INSTR_NONE;
      case (w.symbol)
         SYM_ADD: opcode = INSTR_AD;
         SYM_SUB: opcode = INSTR_SB;
         SYM_MUL: opcode = INSTR_ML;
         SYM_DIV: opcode = INSTR_DV;
         default: is_op = 1'b0;
      endcase
      sym_entry.is_temp = 1'b0;
      sym_entry.value   = w.symbol;
      if (is_op) begin
         pop_entry(right, err_right);
         pop_entry(left, err_left);
         err_store = ERR_NONE;
         if (temp_num == TEMP_MAX) err_store = ERR_TEMP;
         else temp_num = temp_num + 8'd1;
         temp_entry.is_temp = 1'b1;
         temp_entry.value   = temp_num;
         if (!push_entry(temp_entry) && err_store == ERR_NONE) err_store = ERR_OVER;
         add_word(INSTR_LD, left, err_left, 1'b0);
         add_word(opcode, right, err_right, 1'b0);
         add_word(INSTR_ST, temp_entry, err_store, 1'b1);
      end else if (!push_entry(sym_entry)) begin
         add_word(INSTR_NONE, sym_entry, ERR_OVER, 1'b1);
      end
      if (w.end_of_expr) begin
         stack_depth = 0;
         temp_num    = '0;
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         stack_depth = 0;
         temp_num    = '0;
         failures    = 0;
         expected_words.delete();
      end else begin
         // words reach rsp only through the sequencer and output registers, so order here is free
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               failures++;
               $display("%0t: unexpected word: expected none, got %s",
                        $time, word_text(rsp_word));
            end else begin
               want = expected_words.pop_front();
               if (rsp_word.instr !== want.instr || rsp_word.is_temp !== want.is_temp ||
                   rsp_word.operand !== want.operand || rsp_word.error !== want.error ||
                   rsp_word.last !== want.last) begin
                  failures++;
                  $display("%0t: word mismatch: expected %s, got %s",
                           $time, word_text(want), word_text(rsp_word));
               end
            end
         end
         if (req_valid && !req_stall) translate_symbol(req_word);
      end
      mismatch_count    <= failures;
      words_outstanding <= expected_words.size();
   end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, character stimulus, output back-pressure and the verdict.
module tb_top;
   import pfac_pkg::*;

   localparam int STACK_DEPTH     = 128;
   localparam int RANDOM_WORDS    = 136;  // characters in the random part
   localparam int HOLD_OFF_CYCLES = 60;   // long rsp_stall stretch to back the block up

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   int mismatch_count;
   int words_outstanding;

   // quiet: neither side idles; hold_wanted: ask the receiver for one long hold-off
   bit quiet       = 1'b0;
   bit hold_wanted = 1'b0;

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   postfix_to_accumulator_code #(
      .STACK_DEPTH (STACK_DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   accumulator_code_checker #(
      .STACK_DEPTH (STACK_DEPTH)
   ) code_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_word          (req_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_word          (rsp_word),
      .mismatch_count    (mismatch_count),
      .words_outstanding (words_outstanding)
   );

   // Any character that is not one of the four operators.
   function automatic logic [7:0] pick_operand();
      logic [7:0] s;
      do s = 8'($urandom_range(255));
      while (s == SYM_ADD || s == SYM_SUB || s == SYM_MUL || s == SYM_DIV);
      return s;
   endfunction

   function automatic logic [7:0] pick_operator();
      case ($urandom_range(3))
         0:       return SYM_ADD;
         1:       return SYM_SUB;
         2:       return SYM_MUL;
         default: return SYM_DIV;
      endcase
   endfunction

   // Offer one character word and hold it until accepted. Idle cycles go in
   // front of the word, so valid is never dropped and raised in the same step.
   task automatic send_word(input logic [7:0] sym, input logic eoe);
      while (!quiet && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_word  <= '{symbol: sym, end_of_expr: eoe};
      req_valid <= 1'b1;
      do @(posedge clock);
      while (req_stall);
   endtask

   // Receiver: random stalls at about 8%, none while quiet, plus one long
   // hold-off whose length is counted here.
   initial begin
      forever begin
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 8);
            @(posedge clock);
         end
      end
   end

   initial begin
      logic [7:0] expr_syms [$];
      int         operands_left;
      int         depth;
      int         sent;
      bit         keep_end;
      bit         hold_done;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: operators on an empty stack (both pops underflow, then only
      // the left one), end mark on an operator.
      send_word(SYM_ADD, 1'b0);
      send_word(SYM_SUB, 1'b0);
      send_word(SYM_MUL, 1'b1);
      // operand code extremes and every operator
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(SYM_DIV, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(SYM_MUL, 1'b0);
      send_word(8'h7F, 1'b0);
      send_word(SYM_SUB, 1'b0);
      send_word(8'h55, 1'b0);
      send_word(SYM_ADD, 1'b1);
      // lone operand with the end mark, then an operator alone with the end mark
      send_word(8'hAA, 1'b1);
      send_word(SYM_DIV, 1'b1);

      // Random part: mostly well-formed expressions with random operands and
      // operators, some without the end mark, the rest random noise.
      sent      = 0;
      hold_done = 1'b0;
      while (sent < RANDOM_WORDS) begin
         quiet = (sent >= 40 && sent < 80);
         if (!hold_done && sent >= 90) begin
            // receiver holds off while operator words keep coming: the output
            // register fills and req_stall has to rise
            hold_done   = 1'b1;
            hold_wanted = 1'b1;
            send_word(pick_operand(), 1'b0);
            repeat (6) begin
               send_word(pick_operand(), 1'b0);
               send_word(pick_operator(), 1'b0);
            end
            sent += 13;
         end
         if ($urandom_range(99) < 80) begin
            expr_syms.delete();
            operands_left = $urandom_range(1, 8);
            depth         = 0;
            while (operands_left > 0 || depth > 1) begin
               if (depth >= 2 && (operands_left == 0 || $urandom_range(1) == 1)) begin
                  expr_syms.push_back(pick_operator());
                  depth--;
               end else begin
                  expr_syms.push_back(pick_operand());
                  depth++;
                  operands_left--;
               end
            end
            keep_end = ($urandom_range(9) != 0);
            foreach (expr_syms[i])
               send_word(expr_syms[i], keep_end && (i == expr_syms.size() - 1));
            sent += expr_syms.size();
         end else begin
            send_word(8'($urandom_range(255)), $urandom_range(7) == 0);
            sent++;
         end
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      // let the registered count cover the last character, then drain
      @(posedge clock);
      while (words_outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0 && words_outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #200000;
      $display("simulation failed");
      $finish;
   end

endmodule

### postfix_to_accumulator_code.f
sv/pfac_pkg.sv
sv/pfac_ram.sv
sv/pfac_stack_ctrl.sv
sv/pfac_emit.sv
sv/postfix_to_accumulator_code.sv
bench/accumulator_code_checker.sv
bench/tb_top.sv
